### design/matrix_inverse_cofactor_macros.svh
// Assertion helpers for the block's top-level RTL.
`ifndef MATRIX_INVERSE_COFACTOR_MACROS_SVH
`define MATRIX_INVERSE_COFACTOR_MACROS_SVH

// Property checked on every clock, masked while reset is active.
`define MIC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define MIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### design/mic_pkg.sv
package mic_pkg;

  localparam int unsigned DIM       = 4;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned IdxW      = 2;
  localparam int unsigned AddrW     = 2 * IdxW;
  localparam int unsigned Depth     = 1 << AddrW;
  localparam int unsigned DataW     = 32;
  localparam int unsigned DivW      = DataW + FRAC_BITS;
  localparam int unsigned DivCntW   = $clog2(DivW + 1);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(DIM - 1);
  localparam bit              DimBig  = (DIM == 4);

  typedef logic signed [DataW-1:0] fx_t;

  localparam fx_t FxMax = {1'b0, {(DataW-1){1'b1}}};
  localparam fx_t FxMin = {1'b1, {(DataW-1){1'b0}}};

  typedef struct packed {
    logic [IdxW-1:0] row_index;
    logic [IdxW-1:0] col_index;
    fx_t             element_value;
    logic            load_done;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0] out_row;
    logic [IdxW-1:0] out_col;
    fx_t             out_value;
    logic            singular;
    logic            end_of_run;
  } out_item_t;

  typedef struct packed {
    logic start;
    fx_t  num;
    fx_t  den;
  } div_req_t;

  typedef struct packed {
    logic done;
    fx_t  quo;
  } div_rsp_t;

  function automatic fx_t fx_sat(input logic signed [2*DataW-1:0] v);
    logic signed [2*DataW-1:0] hi;
    logic signed [2*DataW-1:0] lo;
    hi = {{(DataW+1){1'b0}}, {(DataW-1){1'b1}}};
    lo = {{(DataW+1){1'b1}}, {(DataW-1){1'b0}}};
    if (v > hi) return FxMax;
    if (v < lo) return FxMin;
    return v[DataW-1:0];
  endfunction

  // Floor shift of the exact product, then clamp.
  function automatic fx_t fx_mul_post(input logic signed [2*DataW-1:0] p);
    return fx_sat(p >>> FRAC_BITS);
  endfunction

  function automatic fx_t fx_clamp33(input logic signed [DataW:0] s);
    if (s[DataW] != s[DataW-1]) return s[DataW] ? FxMin : FxMax;
    return s[DataW-1:0];
  endfunction

  function automatic fx_t fx_add(input fx_t a, input fx_t b);
    logic signed [DataW:0] s;
    s = {a[DataW-1], a} + {b[DataW-1], b};
    return fx_clamp33(s);
  endfunction

  function automatic fx_t fx_sub(input fx_t a, input fx_t b);
    logic signed [DataW:0] s;
    s = {a[DataW-1], a} - {b[DataW-1], b};
    return fx_clamp33(s);
  endfunction

  function automatic fx_t fx_neg(input fx_t a);
    return (a == FxMin) ? FxMax : -a;
  endfunction

  // k-th surviving index when index skip is struck out.
  function automatic logic [IdxW-1:0] lst(input logic [IdxW-1:0] k,
                                          input logic [IdxW-1:0] skip);
    return (k < skip) ? k : k + IdxW'(1);
  endfunction

endpackage

### design/mic_ram.sv
module mic_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### design/mic_div.sv
module mic_div import mic_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic               busy_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivW-1:0]    num_q;
  logic [DivW-1:0]    quo_q;
  logic [DataW-1:0]   rem_q;
  logic [DataW-1:0]   den_q;
  logic               neg_q;
  logic               done_q;
  fx_t                res_q;

  logic [DataW:0]   trial;
  logic [DataW:0]   diff;
  logic             ge;
  logic [DataW-1:0] rem_nx;
  logic [DivW-1:0]  quo_nx;
  logic [DataW-1:0] num_mag;
  logic [DataW-1:0] den_mag;
  logic [DivW-1:0]  max_mag;
  fx_t              sat_val;

  assign trial   = {rem_q, num_q[DivW-1]};
  assign diff    = trial - {1'b0, den_q};
  assign ge      = trial >= {1'b0, den_q};
  assign rem_nx  = ge ? diff[DataW-1:0] : trial[DataW-1:0];
  assign quo_nx  = {quo_q[DivW-2:0], ge};
  assign num_mag = req_i.num[DataW-1] ? (~req_i.num + 1'b1) : req_i.num;
  assign den_mag = req_i.den[DataW-1] ? (~req_i.den + 1'b1) : req_i.den;
  assign max_mag = {{FRAC_BITS{1'b0}}, 1'b0, {(DataW-1){1'b1}}};

  always_comb begin
    if (!neg_q) begin
      sat_val = (quo_nx > max_mag) ? FxMax : quo_nx[DataW-1:0];
    end else begin
      sat_val = (quo_nx > max_mag + 1'b1) ? FxMin : -quo_nx[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      neg_q  <= 1'b0;
      done_q <= 1'b0;
      res_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        num_q  <= {num_mag, {FRAC_BITS{1'b0}}};
        den_q  <= den_mag;
        rem_q  <= '0;
        quo_q  <= '0;
        neg_q  <= req_i.num[DataW-1] ^ req_i.den[DataW-1];
      end else if (busy_q) begin
        rem_q <= rem_nx;
        quo_q <= quo_nx;
        num_q <= {num_q[DivW-2:0], 1'b0};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          res_q  <= sat_val;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = res_q;

endmodule

### design/matrix_inverse_cofactor.sv
// Matrix inverse by cofactor expansion, signed Q16.16. Each element transfer is written
// to a 16-entry memory at row*4+col. The element marked last starts an inversion,
// during which in_stall_o stays high. Every product is a 32x32 multiply into one
// product register, with an operand from the memory's single read port. The
// determinant is expanded along row 0, then each of the 16 inverse elements takes its
// own 3x3 cofactor and a pass through the bit-serial divider; a singular matrix ends
// after the determinant with a single result. Output stalls hold the sequence. The
// output register decouples result transfers; a new load may start while the last
// result still waits.
`include "matrix_inverse_cofactor_macros.svh"

module matrix_inverse_cofactor import mic_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_RA, S_RB, S_M1, S_P1, S_RD, S_M2, S_P2, S_M3, S_P3,
    S_TRD, S_TM, S_TP, S_DIV, S_EMIT
  } state_e;

  state_e                    state_q;
  logic                      phase_inv_q;
  logic [IdxW-1:0]           cof_r_q, cof_c_q, j3_q, jt_q, oi_q, oj_q;
  fx_t                       x_q, p1_q, m_q, acc3_q, cof_q, det_q;
  logic signed [2*DataW-1:0] prod_q;
  logic                      div_start_q;
  out_item_t                 res_q;
  out_item_t                 out_q;
  logic                      out_valid_q;

  logic             in_accept;
  logic             out_free;
  logic             out_load;
  logic [AddrW-1:0] raddr;
  logic [DataW-1:0] rdata;
  fx_t              rd_fx;
  logic [IdxW-1:0]  r0, r1, r2, ca, cb;
  fx_t              m_val, acc_new, det_new, fin_src, fin_val;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == S_EMIT) && out_free;
  assign rd_fx      = rdata;

  // Rows and columns of the current det2 term inside the struck-out minor.
  always_comb begin
    r0 = lst(IdxW'(0), cof_r_q);
    if (DimBig) begin
      r1 = lst(IdxW'(1), cof_r_q);
      r2 = lst(IdxW'(2), cof_r_q);
      ca = lst((j3_q == IdxW'(0)) ? IdxW'(1) : IdxW'(0), cof_c_q);
      cb = lst((j3_q == IdxW'(2)) ? IdxW'(1) : IdxW'(2), cof_c_q);
    end else begin
      r1 = lst(IdxW'(0), cof_r_q);
      r2 = lst(IdxW'(1), cof_r_q);
      ca = lst(IdxW'(0), cof_c_q);
      cb = lst(IdxW'(1), cof_c_q);
    end
  end

  always_comb begin
    unique case (state_q)
      S_RA:    raddr = {r1, ca};
      S_RB:    raddr = {r2, cb};
      S_P1:    raddr = {r1, cb};
      S_RD:    raddr = {r2, ca};
      S_P2:    raddr = {r0, lst(j3_q, cof_c_q)};
      S_TRD:   raddr = {IdxW'(0), jt_q};
      default: raddr = '0;
    endcase
  end

  assign m_val   = fx_sub(p1_q, fx_mul_post(prod_q));
  assign acc_new = fx_add(acc3_q, fx_mul_post(prod_q));
  assign det_new = fx_add(det_q, fx_mul_post(prod_q));
  assign fin_src = (state_q == S_P3) ? acc_new : m_val;
  assign fin_val = (cof_r_q[0] ^ cof_c_q[0]) ? fx_neg(fin_src) : fin_src;

  mic_ram #(
    .Width(DataW),
    .Depth(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (in_accept),
    .waddr_i({in_item_i.row_index, in_item_i.col_index}),
    .wdata_i(in_item_i.element_value),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign div_req.start = div_start_q;
  assign div_req.num   = cof_q;
  assign div_req.den   = det_q;

  mic_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_inv_q <= 1'b0;
      cof_r_q     <= '0;
      cof_c_q     <= '0;
      j3_q        <= '0;
      jt_q        <= '0;
      oi_q        <= '0;
      oj_q        <= '0;
      x_q         <= '0;
      p1_q        <= '0;
      m_q         <= '0;
      acc3_q      <= '0;
      cof_q       <= '0;
      det_q       <= '0;
      prod_q      <= '0;
      div_start_q <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // start is high only in the first divide cycle, never while it is being set
      if (div_start_q) begin
        div_start_q <= 1'b0;
      end
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept && in_item_i.load_done) begin
            phase_inv_q <= 1'b0;
            jt_q        <= '0;
            det_q       <= '0;
            cof_r_q     <= '0;
            cof_c_q     <= '0;
            j3_q        <= '0;
            acc3_q      <= '0;
            state_q     <= S_RA;
          end
        end
        S_RA: state_q <= S_RB;
        S_RB: begin
          x_q     <= rd_fx;
          state_q <= S_M1;
        end
        S_M1: begin
          prod_q  <= x_q * rd_fx;
          state_q <= S_P1;
        end
        S_P1: begin
          p1_q    <= fx_mul_post(prod_q);
          state_q <= S_RD;
        end
        S_RD: begin
          x_q     <= rd_fx;
          state_q <= S_M2;
        end
        S_M2: begin
          prod_q  <= x_q * rd_fx;
          state_q <= S_P2;
        end
        S_P2, S_P3: begin
          if (DimBig && state_q == S_P2) begin
            m_q     <= j3_q[0] ? fx_neg(m_val) : m_val;
            state_q <= S_M3;
          end else if (state_q == S_P3 && j3_q != IdxW'(2)) begin
            acc3_q  <= acc_new;
            j3_q    <= j3_q + 1'b1;
            state_q <= S_RA;
          end else begin
            cof_q <= fin_val;
            if (phase_inv_q) begin
              div_start_q <= 1'b1;
              state_q     <= S_DIV;
            end else begin
              state_q <= S_TRD;
            end
          end
        end
        S_M3: begin
          prod_q  <= rd_fx * m_q;
          state_q <= S_P3;
        end
        S_TRD: state_q <= S_TM;
        S_TM: begin
          prod_q  <= rd_fx * cof_q;
          state_q <= S_TP;
        end
        S_TP: begin
          det_q  <= det_new;
          j3_q   <= '0;
          acc3_q <= '0;
          if (jt_q == LastIdx) begin
            if (det_new == '0) begin
              res_q   <= '{out_row: '0, out_col: '0, out_value: '0,
                           singular: 1'b1, end_of_run: 1'b1};
              state_q <= S_EMIT;
            end else begin
              phase_inv_q <= 1'b1;
              oi_q        <= '0;
              oj_q        <= '0;
              cof_r_q     <= '0;
              cof_c_q     <= '0;
              state_q     <= S_RA;
            end
          end else begin
            jt_q    <= jt_q + 1'b1;
            cof_r_q <= '0;
            cof_c_q <= jt_q + 1'b1;
            state_q <= S_RA;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            res_q   <= '{out_row: oi_q, out_col: oj_q, out_value: div_rsp.quo,
                         singular: 1'b0,
                         end_of_run: (oi_q == LastIdx) && (oj_q == LastIdx)};
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            j3_q        <= '0;
            acc3_q      <= '0;
            if (res_q.end_of_run) begin
              state_q <= S_IDLE;
            end else if (oj_q == LastIdx) begin
              // inverse (i,j) needs cofactor (j,i)
              oj_q    <= '0;
              oi_q    <= oi_q + 1'b1;
              cof_r_q <= '0;
              cof_c_q <= oi_q + 1'b1;
              state_q <= S_RA;
            end else begin
              oj_q    <= oj_q + 1'b1;
              cof_r_q <= oj_q + 1'b1;
              cof_c_q <= oi_q;
              state_q <= S_RA;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `MIC_ASSERT(a_sing_is_last, out_valid_o && out_item_o.singular |-> out_item_o.end_of_run, "singular result not marked end of run")
  `MIC_ASSERT(a_div_done_state, div_rsp.done |-> (state_q == S_DIV), "divider finished outside its wait state")
  `MIC_ASSERT(a_no_overwrite, out_load |-> (!out_valid_q || !out_stall_i), "output register overwritten while stalled")
  `MIC_ASSERT_NEXT(a_start_pulse, div_start_q, !div_start_q && state_q == S_DIV, "divider start not a single pulse")

endmodule
